>>> hw/rtl/lru_cache_replacement_assert.svh
// Assertion macros shared by the LRU cache replacement RTL.
`ifndef LRU_CACHE_REPLACEMENT_ASSERT_SVH
`define LRU_CACHE_REPLACEMENT_ASSERT_SVH

// Checks a condition at every clock edge outside reset.
`define LRU_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Checks that a condition in one cycle implies another in the next cycle.
`define LRU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/lru_pkg.sv
// Shared types and constants for the LRU cache replacement block.
package lru_pkg;

    localparam int REF_TAG_W  = 16;
    localparam int SLOT_OUT_W = 4;
    localparam int ACTIVE_W   = 5;
    localparam int HIT_W      = 32;
    localparam int APB_DATA_W = 32;
    localparam int PADDR_W    = 3;

    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd16;
    localparam logic [HIT_W-1:0]    HIT_MAX      = 32'hFFFF_FFFF;

    localparam logic [PADDR_W-3:0]  REG_ACTIVE_SLOTS = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_LOOKUP = 3'b010,
        ST_UPDATE = 3'b100
    } lru_state_t;

    typedef struct packed {
        logic capture;
        logic lookup;
        logic commit;
    } lru_cmd_t;

endpackage

>>> hw/rtl/lru_ctrl.sv
// Controller state machine that sequences lookup, update and result handoff.
module lru_ctrl
    import lru_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     ref_valid,
    output logic     ref_ready,
    output logic     res_valid,
    input  logic     res_ready,
    output lru_cmd_t cmd
);

    lru_state_t state_reg;
    lru_state_t state_next;
    logic       res_valid_reg;
    logic       res_valid_next;
    logic       out_free;

    always_comb
    begin
        out_free    = !res_valid_reg || res_ready;
        cmd.commit  = (state_reg == ST_UPDATE) && out_free;
        cmd.lookup  = (state_reg == ST_LOOKUP);
        ref_ready   = (state_reg == ST_IDLE) || cmd.commit;
        cmd.capture = ref_valid && ref_ready;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.capture)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (cmd.commit)
                begin
                    state_next = cmd.capture ? ST_LOOKUP : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.commit)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign res_valid = res_valid_reg;

`include "lru_cache_replacement_assert.svh"

    `LRU_ASSERT_NEXT(a_capture_to_lookup, cmd.capture, state_reg == ST_LOOKUP, "no lookup after capture")
    `LRU_ASSERT_NEXT(a_lookup_to_update, state_reg == ST_LOOKUP, state_reg == ST_UPDATE, "lookup not followed by update")
    `LRU_ASSERT_NEXT(a_commit_shows_result, cmd.commit, res_valid_reg, "committed result not presented")

endmodule

>>> hw/rtl/lru_datapath.sv
// Datapath with the tag store, recency ranks, lookup registers and hit counter.
module lru_datapath
    import lru_pkg::*;
#(
    parameter int SLOTS    = 16,
    parameter int TAG_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  lru_cmd_t              cmd,
    input  logic                  flush,
    input  logic [ACTIVE_W-1:0]   active_slots,
    input  logic [REF_TAG_W-1:0]  ref_tag,
    output logic                  hit,
    output logic [SLOT_OUT_W-1:0] slot_used,
    output logic                  evicted_valid,
    output logic [REF_TAG_W-1:0]  evicted_tag,
    output logic [HIT_W-1:0]      hit_total
);

    localparam int RW    = $clog2(SLOTS);
    localparam int TWIDE = (TAG_BITS > REF_TAG_W) ? TAG_BITS : REF_TAG_W;
    localparam int SOW   = (RW > SLOT_OUT_W) ? RW : SLOT_OUT_W;

    logic [TAG_BITS-1:0] tag_in_reg;
    logic [TAG_BITS-1:0] tag_reg [SLOTS];
    logic [SLOTS-1:0]    valid_reg;
    logic [RW-1:0]       rank_reg [SLOTS];
    logic [HIT_W-1:0]    hit_count_reg;
    logic [HIT_W-1:0]    hit_count_next;

    logic                hit_l_reg;
    logic [SLOTS-1:0]    sel_l_reg;
    logic                age_all_l_reg;
    logic [RW-1:0]       limit_l_reg;
    logic                ev_valid_l_reg;
    logic [TAG_BITS-1:0] ev_tag_l_reg;

    logic [TWIDE-1:0]    tag_in_wide;
    logic [SLOTS-1:0]    active_vec;
    logic [SLOTS-1:0]    match_vec;
    logic [SLOTS-1:0]    empty_vec;
    logic [SLOTS-1:0]    oldest_vec;
    logic [SLOTS-1:0]    match_low;
    logic [SLOTS-1:0]    empty_low;
    logic [SLOTS-1:0]    oldest_low;
    logic [SLOTS-1:0]    sel_vec;
    logic                any_hit;
    logic                any_empty;
    logic [RW-1:0]       last_rank;
    logic [RW-1:0]       hit_rank;
    logic [RW-1:0]       limit_val;
    logic [TAG_BITS-1:0] sel_tag;
    logic [RW-1:0]       sel_idx;
    logic [SOW-1:0]      sel_idx_wide;
    logic [TWIDE-1:0]    ev_tag_wide;

    assign tag_in_wide = TWIDE'(ref_tag);

    always_comb
    begin
        if (active_slots == '0)
        begin
            last_rank = '0;
        end
        else if (int'(active_slots) > SLOTS)
        begin
            last_rank = RW'(SLOTS - 1);
        end
        else
        begin
            last_rank = RW'(active_slots - ACTIVE_W'(1));
        end
    end

    always_comb
    begin
        for (int k = 0; k < SLOTS; k++)
        begin
            active_vec[k] = (k == 0) || (int'(active_slots) > k);
            match_vec[k]  = valid_reg[k] && active_vec[k] && (tag_reg[k] == tag_in_reg);
            empty_vec[k]  = !valid_reg[k] && active_vec[k];
            oldest_vec[k] = active_vec[k] && (rank_reg[k] == last_rank);
        end
        match_low  = match_vec & (~match_vec + SLOTS'(1));
        empty_low  = empty_vec & (~empty_vec + SLOTS'(1));
        oldest_low = oldest_vec & (~oldest_vec + SLOTS'(1));
        any_hit    = |match_vec;
        any_empty  = |empty_vec;
        if (any_hit)
        begin
            sel_vec = match_low;
        end
        else if (any_empty)
        begin
            sel_vec = empty_low;
        end
        else
        begin
            sel_vec = oldest_low;
        end
    end

    always_comb
    begin
        hit_rank = '0;
        sel_tag  = '0;
        for (int k = 0; k < SLOTS; k++)
        begin
            if (sel_vec[k])
            begin
                hit_rank = hit_rank | rank_reg[k];
                sel_tag  = sel_tag | tag_reg[k];
            end
        end
        limit_val = any_hit ? hit_rank : last_rank;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            tag_in_reg <= tag_in_wide[TAG_BITS-1:0];
        end
        if (cmd.lookup)
        begin
            hit_l_reg      <= any_hit;
            sel_l_reg      <= sel_vec;
            age_all_l_reg  <= !any_hit && any_empty;
            limit_l_reg    <= limit_val;
            ev_valid_l_reg <= !any_hit && !any_empty;
            ev_tag_l_reg   <= (!any_hit && !any_empty) ? sel_tag : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && !hit_l_reg)
        begin
            for (int k = 0; k < SLOTS; k++)
            begin
                if (sel_l_reg[k])
                begin
                    tag_reg[k] <= tag_in_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            for (int k = 0; k < SLOTS; k++)
            begin
                rank_reg[k] <= '0;
            end
        end
        else if (flush)
        begin
            valid_reg <= '0;
            for (int k = 0; k < SLOTS; k++)
            begin
                rank_reg[k] <= '0;
            end
        end
        else if (cmd.commit)
        begin
            for (int k = 0; k < SLOTS; k++)
            begin
                if (sel_l_reg[k])
                begin
                    rank_reg[k]  <= '0;
                    valid_reg[k] <= 1'b1;
                end
                else if (valid_reg[k] && active_vec[k]
                         && (age_all_l_reg || (rank_reg[k] < limit_l_reg))
                         && (rank_reg[k] != RW'(SLOTS - 1)))
                begin
                    rank_reg[k] <= rank_reg[k] + RW'(1);
                end
            end
        end
    end

    always_comb
    begin
        hit_count_next = hit_count_reg;
        if (hit_l_reg && (hit_count_reg != HIT_MAX))
        begin
            hit_count_next = hit_count_reg + HIT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_count_reg <= '0;
        end
        else if (cmd.commit)
        begin
            hit_count_reg <= hit_count_next;
        end
    end

    always_comb
    begin
        sel_idx = '0;
        for (int k = 0; k < SLOTS; k++)
        begin
            if (sel_l_reg[k])
            begin
                sel_idx = sel_idx | RW'(k);
            end
        end
        sel_idx_wide = SOW'(sel_idx);
        ev_tag_wide  = TWIDE'(ev_tag_l_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            hit           <= hit_l_reg;
            slot_used     <= sel_idx_wide[SLOT_OUT_W-1:0];
            evicted_valid <= ev_valid_l_reg;
            evicted_tag   <= ev_tag_wide[REF_TAG_W-1:0];
            hit_total     <= hit_count_next;
        end
    end

`include "lru_cache_replacement_assert.svh"

    `LRU_ASSERT_ALWAYS(a_sel_onehot, !cmd.commit || $onehot(sel_l_reg), "selected slot not one-hot")

endmodule

>>> hw/rtl/lru_cache_replacement.sv
// Top level of the fully associative LRU cache replacement block.
// A result is presented after its transaction passes the lookup and update states.
// A new transaction is accepted only while idle or as the previous one commits.
// A held result stalls write-back and later tags; a tag can still be taken while idle.
// Reset clears all valid bits, ranks and the hit count, and sets active_slots to 16.
module lru_cache_replacement
    import lru_pkg::*;
#(
    parameter int SLOTS    = 16,
    parameter int TAG_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  ref_valid,
    output logic                  ref_ready,
    input  logic [REF_TAG_W-1:0]  ref_tag,
    output logic                  res_valid,
    input  logic                  res_ready,
    output logic                  hit,
    output logic [SLOT_OUT_W-1:0] slot_used,
    output logic                  evicted_valid,
    output logic [REF_TAG_W-1:0]  evicted_tag,
    output logic [HIT_W-1:0]      hit_total
);

    logic [ACTIVE_W-1:0] active_reg;
    logic                cfg_write;
    logic                flush;
    lru_cmd_t            cmd;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign flush     = cfg_write && (paddr[PADDR_W-1:2] == REG_ACTIVE_SLOTS);
    assign prdata    = (paddr[PADDR_W-1:2] == REG_ACTIVE_SLOTS) ?
                       APB_DATA_W'(active_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= ACTIVE_RESET;
        end
        else if (flush)
        begin
            active_reg <= pwdata[ACTIVE_W-1:0];
        end
    end

    lru_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .ref_valid (ref_valid),
        .ref_ready (ref_ready),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .cmd       (cmd)
    );

    lru_datapath #(
        .SLOTS    (SLOTS),
        .TAG_BITS (TAG_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .flush         (flush),
        .active_slots  (active_reg),
        .ref_tag       (ref_tag),
        .hit           (hit),
        .slot_used     (slot_used),
        .evicted_valid (evicted_valid),
        .evicted_tag   (evicted_tag),
        .hit_total     (hit_total)
    );

endmodule

>>> test/tb.sv
// Self-checking testbench for the LRU cache replacement block, with its own lookup predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lru_pkg::*;

    localparam int NUM_SLOTS   = 16;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic                  hit;
        logic [SLOT_OUT_W-1:0] slot;
        logic                  ev_valid;
        logic [REF_TAG_W-1:0]  ev_tag;
        logic [HIT_W-1:0]      total;
    } lookup_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_W-1:0]    paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  ref_valid;
    logic                  ref_ready;
    logic [REF_TAG_W-1:0]  ref_tag;
    logic                  res_valid;
    logic                  res_ready;
    logic                  hit;
    logic [SLOT_OUT_W-1:0] slot_used;
    logic                  evicted_valid;
    logic [REF_TAG_W-1:0]  evicted_tag;
    logic [HIT_W-1:0]      hit_total;

    logic [REF_TAG_W-1:0] tag_store [NUM_SLOTS];
    bit                   slot_live [NUM_SLOTS];
    int                   age_rank [NUM_SLOTS];
    logic [HIT_W-1:0]     hits_seen = '0;
    logic [ACTIVE_W-1:0]  active_cfg = ACTIVE_RESET;

    lookup_t              pending_lookups [$];
    logic [REF_TAG_W-1:0] tag_pool [$];

    int  mismatches = 0;
    int  lookups_sent = 0;
    int  results_checked = 0;
    int  config_writes = 0;
    int  cycles = 0;
    int  stall_left = 0;
    bit  sender_idles = 0;
    bit  receiver_idles = 0;

    lru_cache_replacement #(
        .SLOTS    (NUM_SLOTS),
        .TAG_BITS (REF_TAG_W)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .ref_valid     (ref_valid),
        .ref_ready     (ref_ready),
        .ref_tag       (ref_tag),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .hit           (hit),
        .slot_used     (slot_used),
        .evicted_valid (evicted_valid),
        .evicted_tag   (evicted_tag),
        .hit_total     (hit_total)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t ns: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
            $display("[lru_cache_replacement] ERROR");
            $finish;
        end
    end

    function automatic int slots_in_use();
        if (active_cfg == 0)
            return 1;
        if (active_cfg > NUM_SLOTS)
            return NUM_SLOTS;
        return active_cfg;
    endfunction

    function automatic void flush_store();
        for (int k = 0; k < NUM_SLOTS; k++)
        begin
            slot_live[k] = 0;
            age_rank[k]  = 0;
        end
    endfunction

    // The chosen slot becomes most recent; younger valid slots age by one.
    function automatic void promote(int n, int s, int limit);
        for (int k = 0; k < n; k++)
        begin
            if (k != s && slot_live[k] && age_rank[k] < limit && age_rank[k] < NUM_SLOTS - 1)
                age_rank[k]++;
        end
        age_rank[s] = 0;
    endfunction

    function automatic lookup_t predict_lookup(logic [REF_TAG_W-1:0] tag);
        lookup_t r;
        int      n;
        int      s;
        int      best;
        bit      found;
        bit      empty;
        n = slots_in_use();
        s = 0;
        best = 0;
        found = 0;
        empty = 0;
        r.ev_valid = 1'b0;
        r.ev_tag = '0;
        for (int k = 0; k < n && !found; k++)
        begin
            if (slot_live[k] && tag_store[k] == tag)
            begin
                s = k;
                found = 1;
            end
        end
        if (found)
        begin
            if (hits_seen != HIT_MAX)
                hits_seen++;
            promote(n, s, age_rank[s]);
        end
        else
        begin
            for (int k = 0; k < n && !empty; k++)
            begin
                if (!slot_live[k])
                begin
                    s = k;
                    empty = 1;
                end
            end
            if (empty)
                promote(n, s, NUM_SLOTS);
            else
            begin
                s = 0;
                for (int k = 0; k < n; k++)
                begin
                    if (age_rank[k] > best)
                    begin
                        best = age_rank[k];
                        s = k;
                    end
                end
                r.ev_valid = 1'b1;
                r.ev_tag = tag_store[s];
                promote(n, s, best);
            end
            tag_store[s] = tag;
            slot_live[s] = 1;
        end
        r.hit = found;
        r.slot = s[SLOT_OUT_W-1:0];
        r.total = hits_seen;
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin : check_results
        lookup_t want;
        if (rst_n && res_valid && res_ready)
        begin
            if (pending_lookups.size() == 0)
            begin
                $display("%0t ns: unexpected result, expected none, actual slot %0d hit %0b",
                         $time, slot_used, hit);
                mismatches++;
            end
            else
            begin
                want = pending_lookups.pop_front();
                check_field("hit", want.hit, hit);
                check_field("slot_used", want.slot, slot_used);
                check_field("evicted_valid", want.ev_valid, evicted_valid);
                check_field("evicted_tag", want.ev_tag, evicted_tag);
                check_field("hit_total", want.total, hit_total);
                results_checked++;
            end
        end
    end

    initial
    begin
        res_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left == 0 && receiver_idles && $urandom_range(0, 4) == 0)
                stall_left = $urandom_range(1, 6);
            if (stall_left > 0)
            begin
                res_ready = 1'b0;
                stall_left--;
            end
            else
                res_ready = 1'b1;
        end
    end

    task automatic issue_tag(logic [REF_TAG_W-1:0] tag);
        int gap;
        @(negedge clk);
        if (sender_idles && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 6);
            ref_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        ref_valid = 1'b1;
        ref_tag = tag;
        do
            @(posedge clk);
        while (!ref_ready);
        pending_lookups.insert(pending_lookups.size(), predict_lookup(tag));
        lookups_sent++;
    endtask

    task automatic settle_inputs();
        @(negedge clk);
        ref_valid = 1'b0;
        while (pending_lookups.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(int index, logic [APB_DATA_W-1:0] value);
        logic [APB_DATA_W-1:0] readback;
        settle_inputs();
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = PADDR_W'(index * 4);
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        if (index == REG_ACTIVE_SLOTS)
        begin
            active_cfg = value[ACTIVE_W-1:0];
            flush_store();
        end
        config_writes++;
        @(negedge clk);
        penable = 1'b0;
        pwrite = 1'b0;
        if (index == REG_ACTIVE_SLOTS)
        begin
            @(negedge clk);
            penable = 1'b1;
            @(posedge clk);
            readback = prdata;
            check_field("active_slots readback", active_cfg, readback);
            @(negedge clk);
            penable = 1'b0;
        end
        psel = 1'b0;
    endtask

    function automatic logic [REF_TAG_W-1:0] pick_tag();
        if (tag_pool.size() != 0 && $urandom_range(0, 99) < 80)
            return tag_pool[$urandom_range(0, tag_pool.size() - 1)];
        return REF_TAG_W'($urandom());
    endfunction

    task automatic test_directed_fill();
        issue_tag(16'h0000);
        issue_tag(16'hFFFF);
        issue_tag(16'h0000);
        write_reg(REG_ACTIVE_SLOTS, 32'd4);
        issue_tag(16'hAAAA);
        issue_tag(16'h5555);
        issue_tag(16'h0000);
        issue_tag(16'hFFFF);
        issue_tag(16'h5555);
        issue_tag(16'h1234);
        issue_tag(16'hAAAA);
    endtask

    // Out-of-range counts, an ignored register index, and masking of upper data bits.
    task automatic test_slot_count_limits();
        write_reg(REG_ACTIVE_SLOTS, 32'd0);
        issue_tag(16'h00FF);
        issue_tag(16'h00FF);
        issue_tag(16'hFF00);
        write_reg(REG_ACTIVE_SLOTS + 1, 32'd2);
        issue_tag(16'hFF00);
        write_reg(REG_ACTIVE_SLOTS, 32'hFFFF_FFE2);
        issue_tag(16'h0F0F);
        issue_tag(16'hF0F0);
        issue_tag(16'h0F0F);
        issue_tag(16'h8001);
        write_reg(REG_ACTIVE_SLOTS, 32'd31);
        issue_tag(16'h7FFE);
    endtask

    task automatic test_random_traffic();
        int counts [11] = '{1, 2, 3, 5, 8, 12, 15, 16, 0, 31, 0};
        int pool_size;
        counts[10] = $urandom_range(0, 31);
        for (int p = 0; p < 11; p++)
        begin
            write_reg(REG_ACTIVE_SLOTS, counts[p]);
            sender_idles = ($urandom_range(0, 3) != 0);
            receiver_idles = ($urandom_range(0, 3) != 0);
            pool_size = $urandom_range(1, 2 * slots_in_use() + 2);
            tag_pool.delete();
            repeat (pool_size) tag_pool.insert(tag_pool.size(), REF_TAG_W'($urandom()));
            repeat (120) issue_tag(pick_tag());
        end
    endtask

    task automatic test_steady_stream();
        write_reg(REG_ACTIVE_SLOTS, 32'd16);
        sender_idles = 0;
        receiver_idles = 0;
        tag_pool.delete();
        repeat (20) tag_pool.insert(tag_pool.size(), REF_TAG_W'($urandom()));
        repeat (200) issue_tag(pick_tag());
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        ref_valid = 1'b0;
        ref_tag = '0;
        flush_store();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_fill();
        test_slot_count_limits();
        test_random_traffic();
        test_steady_stream();

        settle_inputs();
        repeat (8) @(posedge clk);
        $display("Checked %0d of %0d lookups, %0d of them hits, across %0d register writes.",
                 results_checked, lookups_sent, hits_seen, config_writes);
        $display("Slot counts from 1 to 16 and out of range were used, with and without stalls.");
        if (mismatches == 0 && pending_lookups.size() == 0)
            $display("[lru_cache_replacement] OK");
        else
            $display("[lru_cache_replacement] ERROR");
        $finish;
    end

endmodule
